/* design/qe_zyx_pkg.sv */
// package: shared types, constants and tables of the quaternion to euler block
`default_nettype none
package qe_zyx_pkg;

   localparam int Q14_W        = 16;
   localparam int MUL_W        = 32;
   localparam int PROD_W       = 64;
   localparam int ACC_W        = 33;
   localparam int CW           = 38;
   localparam int ZW           = 27;
   localparam int RAD_W        = 58;
   localparam int ROOT_W       = 29;
   localparam int REM_W        = 31;
   localparam int SQRT_STEPS   = 29;
   localparam int ATAN_TAB_LEN = 24;
   localparam int IDX_W        = 5;
   localparam int ATAN_W       = 23;
   localparam int ANG_W        = 19;
   localparam int YAW_W        = 16;
   localparam int PITCH_W      = 15;
   localparam int YAW_LIM      = 23040;
   localparam int PITCH_LIM    = 11520;
   localparam int QUARTER_DEG  = 90 * 65536;
   localparam int ONE_Q28      = 268435456;

   typedef enum logic [3:0] {
      MS_WZ, MS_XY, MS_YY, MS_ZZ, MS_WY, MS_ZX, MS_WX, MS_YZ, MS_XX, MS_SS
   } mul_code_type;

   typedef enum logic [1:0] {
      ANG_YAW, ANG_PITCH, ANG_ROLL
   } angle_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_ACC, ST_CLAMP, ST_SQ_MUL, ST_SQ_LOAD, ST_SQRT,
      ST_ROT_INIT, ST_ROT, ST_ANGLE, ST_EMIT
   } state_type;

   typedef struct packed {
      logic             load;
      logic             mul;
      logic             acc;
      logic             clamp;
      logic             sqrt_load;
      logic             sqrt_step;
      logic             rot_init;
      logic             rot_step;
      logic             angle_store;
      logic             emit;
      mul_code_type     code;
      angle_type        angle;
      logic [IDX_W-1:0] step_idx;
   } qe_cmd_type;

   typedef struct packed {
      logic start_ok;
      logic out_free;
   } qe_status_type;

   // operand pair for each product step of an angle
   function automatic mul_code_type mul_code(angle_type a, logic [1:0] s);
      mul_code_type c;
      c = MS_WZ;
      case (a)
         ANG_YAW: begin
            case (s)
               2'd0:    c = MS_WZ;
               2'd1:    c = MS_XY;
               2'd2:    c = MS_YY;
               default: c = MS_ZZ;
            endcase
         end
         ANG_PITCH: begin
            c = (s == 2'd0) ? MS_WY : MS_ZX;
         end
         default: begin
            case (s)
               2'd0:    c = MS_WX;
               2'd1:    c = MS_YZ;
               2'd2:    c = MS_XX;
               default: c = MS_YY;
            endcase
         end
      endcase
      return c;
   endfunction

   // atan(2^-i) in degrees, 16 fraction bits
   function automatic logic [ATAN_W-1:0] atan_deg16(logic [IDX_W-1:0] i);
      logic [ATAN_W-1:0] v;
      case (i)
         5'd0:    v = 23'd2949120;
         5'd1:    v = 23'd1740967;
         5'd2:    v = 23'd919879;
         5'd3:    v = 23'd466945;
         5'd4:    v = 23'd234379;
         5'd5:    v = 23'd117304;
         5'd6:    v = 23'd58666;
         5'd7:    v = 23'd29335;
         5'd8:    v = 23'd14668;
         5'd9:    v = 23'd7334;
         5'd10:   v = 23'd3667;
         5'd11:   v = 23'd1833;
         5'd12:   v = 23'd917;
         5'd13:   v = 23'd458;
         5'd14:   v = 23'd229;
         5'd15:   v = 23'd115;
         5'd16:   v = 23'd57;
         5'd17:   v = 23'd29;
         5'd18:   v = 23'd14;
         5'd19:   v = 23'd7;
         5'd20:   v = 23'd4;
         5'd21:   v = 23'd2;
         5'd22:   v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

/* design/qe_zyx_ifs.sv */
// interfaces: request and response channels
`default_nettype none
interface qe_req_if #(parameter int QUAT_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic                         fresh;
   logic signed [QUAT_WIDTH-1:0] in_w;
   logic signed [QUAT_WIDTH-1:0] in_x;
   logic signed [QUAT_WIDTH-1:0] in_y;
   logic signed [QUAT_WIDTH-1:0] in_z;
   modport source (output valid, fresh, in_w, in_x, in_y, in_z, input ready);
   modport sink   (input valid, fresh, in_w, in_x, in_y, in_z, output ready);
endinterface

interface qe_rsp_if #(parameter int QUAT_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic                         have_fused;
   logic signed [QUAT_WIDTH-1:0] held_w;
   logic signed [QUAT_WIDTH-1:0] held_x;
   logic signed [QUAT_WIDTH-1:0] held_y;
   logic signed [QUAT_WIDTH-1:0] held_z;
   logic signed [15:0]           yaw_deg;
   logic signed [14:0]           pitch_deg;
   logic signed [15:0]           roll_deg;
   modport source (output valid, have_fused, held_w, held_x, held_y, held_z,
                   yaw_deg, pitch_deg, roll_deg, input ready);
   modport sink   (input valid, have_fused, held_w, held_x, held_y, held_z,
                   yaw_deg, pitch_deg, roll_deg, output ready);
endinterface
`default_nettype wire

/* design/qe_zyx_ctrl.sv */
// controller: sequencer for products, square root and cordic passes
`default_nettype none
module qe_zyx_ctrl #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire qe_zyx_pkg::qe_status_type status,
   output      qe_zyx_pkg::qe_cmd_type    cmd
);
   import qe_zyx_pkg::*;

   localparam int NSTEPS = (CORDIC_STEPS > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STEPS;
   localparam logic [IDX_W-1:0] ROT_LAST  = IDX_W'(NSTEPS - 1);
   localparam logic [IDX_W-1:0] SQRT_LAST = IDX_W'(SQRT_STEPS - 1);

   state_type        state_ff, state_in;
   angle_type        angle_ff, angle_in;
   logic [1:0]       step_ff, step_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             accept;
   logic             last_prod;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign last_prod = (angle_ff == ANG_PITCH) ? (step_ff == 2'd1) : (step_ff == 2'd3);

   // next state
   always_comb begin
      state_in = state_ff;
      angle_in = angle_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            angle_in = ANG_YAW;
            step_in  = 2'd0;
            if (accept) begin
               state_in = status.start_ok ? ST_MUL : ST_EMIT;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (last_prod) begin
               state_in = (angle_ff == ANG_PITCH) ? ST_CLAMP : ST_ROT_INIT;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_CLAMP:   state_in = ST_SQ_MUL;
         ST_SQ_MUL:  state_in = ST_SQ_LOAD;
         ST_SQ_LOAD: begin
            cnt_in   = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SQRT_LAST) state_in = ST_ROT_INIT;
         end
         ST_ROT_INIT: begin
            cnt_in   = '0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ROT_LAST) state_in = ST_ANGLE;
         end
         ST_ANGLE: begin
            step_in = 2'd0;
            case (angle_ff)
               ANG_YAW: begin
                  angle_in = ANG_PITCH;
                  state_in = ST_MUL;
               end
               ANG_PITCH: begin
                  angle_in = ANG_ROLL;
                  state_in = ST_MUL;
               end
               default: state_in = ST_EMIT;
            endcase
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.angle    = angle_ff;
      cmd.step_idx = cnt_ff;
      cmd.code     = mul_code(angle_ff, step_ff);
      case (state_ff)
         ST_IDLE:     cmd.load        = accept;
         ST_MUL:      cmd.mul         = 1'b1;
         ST_ACC:      cmd.acc         = 1'b1;
         ST_CLAMP:    cmd.clamp       = 1'b1;
         ST_SQ_MUL: begin
            cmd.mul  = 1'b1;
            cmd.code = MS_SS;
         end
         ST_SQ_LOAD:  cmd.sqrt_load   = 1'b1;
         ST_SQRT:     cmd.sqrt_step   = 1'b1;
         ST_ROT_INIT: cmd.rot_init    = 1'b1;
         ST_ROT:      cmd.rot_step    = 1'b1;
         ST_ANGLE:    cmd.angle_store = 1'b1;
         ST_EMIT:     cmd.emit        = status.out_free;
         default:     cmd             = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         angle_ff <= ANG_YAW;
         step_ff  <= 2'd0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         angle_ff <= angle_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

/* design/qe_zyx_dp.sv */
// datapath: held quaternion, shared multiplier, square root, cordic, result register
`default_nettype none
module qe_zyx_dp #(
   parameter int QUAT_WIDTH = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_we,
   input  wire logic                         csr_wdata,
   input  wire logic                         req_fresh,
   input  wire logic signed [QUAT_WIDTH-1:0] req_in_w,
   input  wire logic signed [QUAT_WIDTH-1:0] req_in_x,
   input  wire logic signed [QUAT_WIDTH-1:0] req_in_y,
   input  wire logic signed [QUAT_WIDTH-1:0] req_in_z,
   input  wire qe_zyx_pkg::qe_cmd_type       cmd,
   output      qe_zyx_pkg::qe_status_type    status,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic                         rsp_have_fused,
   output      logic signed [QUAT_WIDTH-1:0] rsp_held_w,
   output      logic signed [QUAT_WIDTH-1:0] rsp_held_x,
   output      logic signed [QUAT_WIDTH-1:0] rsp_held_y,
   output      logic signed [QUAT_WIDTH-1:0] rsp_held_z,
   output      logic signed [15:0]           rsp_yaw_deg,
   output      logic signed [14:0]           rsp_pitch_deg,
   output      logic signed [15:0]           rsp_roll_deg
);
   import qe_zyx_pkg::*;

   logic                         enabled_ff;
   logic                         quat_valid_ff;
   logic                         live_ff;
   logic signed [QUAT_WIDTH-1:0] quat_ff [4];
   logic signed [Q14_W-1:0]      q14 [4];

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [ACC_W-1:0]  num_ff, den_ff;
   logic signed [ACC_W:0]    two_num;
   logic signed [ROOT_W:0]   s_ff;
   logic [RAD_W-1:0]         rad_ff;
   logic [ROOT_W-1:0]        root_ff;
   logic [REM_W-1:0]         rem_ff, rem_sh, trial;
   logic signed [CW-1:0]     xv, yv, x_ff, y_ff, dx, dy;
   logic signed [ZW-1:0]     z_ff;
   logic                     zero_ff;
   logic signed [ZW:0]       z_rnd;
   logic signed [ANG_W-1:0]  ang_r, ang_lim, ang_sat;
   logic signed [YAW_W-1:0]  yaw_ff, roll_ff;
   logic signed [PITCH_W-1:0] pitch_ff;
   logic signed [ZW-1:0]     atan_s;

   logic                         rsp_valid_ff;
   logic                         out_fused_ff;
   logic signed [QUAT_WIDTH-1:0] out_q_ff [4];
   logic signed [YAW_W-1:0]      out_yaw_ff, out_roll_ff;
   logic signed [PITCH_W-1:0]    out_pitch_ff;

   assign status.start_ok = enabled_ff && (req_fresh || quat_valid_ff);
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // bring each component to 14 fraction bits
   for (genvar k = 0; k < 4; k++) begin : g_q14
      if (QUAT_WIDTH >= Q14_W) begin : g_narrow
         assign q14[k] = Q14_W'(quat_ff[k] >>> (QUAT_WIDTH - Q14_W));
      end else begin : g_widen
         assign q14[k] = Q14_W'(quat_ff[k]) <<< (Q14_W - QUAT_WIDTH);
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b0;
         quat_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) enabled_ff <= csr_wdata;
         if (cmd.load && enabled_ff && req_fresh) quat_valid_ff <= 1'b1;
         if (cmd.emit)       rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         live_ff <= status.start_ok;
         if (enabled_ff && req_fresh) begin
            quat_ff[0] <= req_in_w;
            quat_ff[1] <= req_in_x;
            quat_ff[2] <= req_in_y;
            quat_ff[3] <= req_in_z;
         end
      end
   end

   // shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.code)
         MS_WZ: begin mul_a = MUL_W'(q14[0]); mul_b = MUL_W'(q14[3]); end
         MS_XY: begin mul_a = MUL_W'(q14[1]); mul_b = MUL_W'(q14[2]); end
         MS_YY: begin mul_a = MUL_W'(q14[2]); mul_b = MUL_W'(q14[2]); end
         MS_ZZ: begin mul_a = MUL_W'(q14[3]); mul_b = MUL_W'(q14[3]); end
         MS_WY: begin mul_a = MUL_W'(q14[0]); mul_b = MUL_W'(q14[2]); end
         MS_ZX: begin mul_a = MUL_W'(q14[3]); mul_b = MUL_W'(q14[1]); end
         MS_WX: begin mul_a = MUL_W'(q14[0]); mul_b = MUL_W'(q14[1]); end
         MS_YZ: begin mul_a = MUL_W'(q14[2]); mul_b = MUL_W'(q14[3]); end
         MS_XX: begin mul_a = MUL_W'(q14[1]); mul_b = MUL_W'(q14[1]); end
         MS_SS: begin mul_a = MUL_W'(s_ff);   mul_b = MUL_W'(s_ff);   end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end
   assign prod_in = mul_a * mul_b;

   assign two_num = {num_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (cmd.mul) prod_ff <= prod_in;
      if (cmd.load || cmd.angle_store) begin
         num_ff <= '0;
         den_ff <= '0;
      end else if (cmd.acc) begin
         case (cmd.code)
            MS_ZX:                 num_ff <= num_ff - prod_ff[ACC_W-1:0];
            MS_YY, MS_ZZ, MS_XX:   den_ff <= den_ff + prod_ff[ACC_W-1:0];
            default:               num_ff <= num_ff + prod_ff[ACC_W-1:0];
         endcase
      end
      // pitch sine clamped to +-1
      if (cmd.clamp) begin
         if (two_num > (ACC_W+1)'(ONE_Q28))       s_ff <= (ROOT_W+1)'(ONE_Q28);
         else if (two_num < -(ACC_W+1)'(ONE_Q28)) s_ff <= -(ROOT_W+1)'(ONE_Q28);
         else                                      s_ff <= two_num[ROOT_W:0];
      end
   end

   // digit-by-digit square root, two radicand bits a step
   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         rad_ff  <= (RAD_W'(1) << 56) - prod_ff[RAD_W-1:0];
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (cmd.sqrt_step) begin
         rad_ff <= rad_ff << 2;
         if (rem_sh >= trial) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // cordic operands for the current angle
   always_comb begin
      if (cmd.angle == ANG_PITCH) begin
         yv = CW'(s_ff);
         xv = CW'({1'b0, root_ff});
      end else begin
         yv = CW'(two_num);
         xv = CW'(ONE_Q28) - CW'({den_ff, 1'b0});
      end
   end

   assign dx     = y_ff >>> cmd.step_idx;
   assign dy     = x_ff >>> cmd.step_idx;
   assign atan_s = ZW'(atan_deg16(cmd.step_idx));

   always_ff @(posedge clock) begin
      if (cmd.rot_init) begin
         zero_ff <= (xv == '0) && (yv == '0);
         if (xv < 0) begin
            if (yv >= 0) begin
               x_ff <= yv;
               y_ff <= -xv;
               z_ff <= ZW'(QUARTER_DEG);
            end else begin
               x_ff <= -yv;
               y_ff <= xv;
               z_ff <= -ZW'(QUARTER_DEG);
            end
         end else begin
            x_ff <= xv;
            y_ff <= yv;
            z_ff <= '0;
         end
      end else if (cmd.rot_step) begin
         if (y_ff >= 0) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + atan_s;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - atan_s;
         end
      end
   end

   // round half up to q9.7 and saturate
   assign z_rnd   = (ZW+1)'(z_ff) + (ZW+1)'(256);
   assign ang_r   = ANG_W'(z_rnd >>> 9);
   assign ang_lim = (cmd.angle == ANG_PITCH) ? ANG_W'(PITCH_LIM) : ANG_W'(YAW_LIM);

   always_comb begin
      if (zero_ff)               ang_sat = '0;
      else if (ang_r > ang_lim)  ang_sat = ang_lim;
      else if (ang_r < -ang_lim) ang_sat = -ang_lim;
      else                       ang_sat = ang_r;
   end

   always_ff @(posedge clock) begin
      if (cmd.angle_store) begin
         case (cmd.angle)
            ANG_YAW:   yaw_ff   <= ang_sat[YAW_W-1:0];
            ANG_PITCH: pitch_ff <= ang_sat[PITCH_W-1:0];
            default:   roll_ff  <= ang_sat[YAW_W-1:0];
         endcase
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_fused_ff <= live_ff;
         for (int k = 0; k < 4; k++) begin
            out_q_ff[k] <= live_ff ? quat_ff[k] : '0;
         end
         out_yaw_ff   <= live_ff ? yaw_ff   : '0;
         out_pitch_ff <= live_ff ? pitch_ff : '0;
         out_roll_ff  <= live_ff ? roll_ff  : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_have_fused = out_fused_ff;
   assign rsp_held_w     = out_q_ff[0];
   assign rsp_held_x     = out_q_ff[1];
   assign rsp_held_y     = out_q_ff[2];
   assign rsp_held_z     = out_q_ff[3];
   assign rsp_yaw_deg    = out_yaw_ff;
   assign rsp_pitch_deg  = out_pitch_ff;
   assign rsp_roll_deg   = out_roll_ff;

endmodule
`default_nettype wire

/* design/quaternion_to_euler_zyx.sv */
// top level: zyx euler angles from a held fusion quaternion
//
//   channel   dir   beat contents
//   req_bus   in    fresh, in_w, in_x, in_y, in_z (quaternion, q1.14 at width 16)
//   rsp_bus   out   have_fused, held_w..held_z, yaw_deg, pitch_deg, roll_deg (q9.7, pitch_deg q8.7)
//   csr_*     in    enabled bit, written when csr_we is high
//
// a computed beat holds the block until its response is registered: eleven products on one
// shared multiplier, a 29-step square root and three cordic passes of N steps on one
// shift-add unit, N = min(CORDIC_STEPS, 24)
// a beat while disabled or before any quaternion goes straight to the response and returns all zeros
// reset is synchronous: disabled, no quaternion held, response empty
// a new request is taken while the last response still waits for rsp ready
`default_nettype none
module quaternion_to_euler_zyx #(
   parameter int QUAT_WIDTH   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic clock,
   input  wire logic reset,
   qe_req_if.sink    req_bus,
   qe_rsp_if.source  rsp_bus,
   input  wire logic csr_we,
   input  wire logic csr_wdata
);
   import qe_zyx_pkg::*;

   // command and status between sequencer and datapath
   qe_cmd_type    cmd;
   qe_status_type status;

   qe_zyx_ctrl #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   qe_zyx_dp #(
      .QUAT_WIDTH (QUAT_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .req_fresh      (req_bus.fresh),
      .req_in_w       (req_bus.in_w),
      .req_in_x       (req_bus.in_x),
      .req_in_y       (req_bus.in_y),
      .req_in_z       (req_bus.in_z),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_have_fused (rsp_bus.have_fused),
      .rsp_held_w     (rsp_bus.held_w),
      .rsp_held_x     (rsp_bus.held_x),
      .rsp_held_y     (rsp_bus.held_y),
      .rsp_held_z     (rsp_bus.held_z),
      .rsp_yaw_deg    (rsp_bus.yaw_deg),
      .rsp_pitch_deg  (rsp_bus.pitch_deg),
      .rsp_roll_deg   (rsp_bus.roll_deg)
   );

endmodule
`default_nettype wire
